### design/mfs_pkg.sv
package mfs_pkg;

  // Field and datapath widths.
  localparam int unsigned IndexW = 62;
  localparam int unsigned ExpW   = 63;
  localparam int unsigned ValW   = 30;
  localparam int unsigned UaddrW = 4;
  localparam int unsigned CntW   = 6;

  // Modulus, Barrett factor floor(2^60 / P), and the final offset.
  localparam logic [29:0] ModP      = 30'd1000000007;
  localparam logic [30:0] BarrettMu = 31'd1152921496;
  localparam logic [29:0] Offset    = 30'd2;
  localparam logic [5:0]  ExpBits   = 6'd63;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_INIT,
    ALU_TWOB_A,
    ALU_ADD_DE,
    ALU_UPDATE,
    ALU_SUM_AB,
    ALU_SUB_OFS
  } alu_op_e;

  typedef enum logic [2:0] {
    REG_A,
    REG_B,
    REG_T,
    REG_C,
    REG_D,
    REG_E
  } reg_e;

  typedef enum logic [2:0] {
    SQ_IN,
    SQ_NEXT,
    SQ_SKIP,
    SQ_LOOP,
    SQ_OUT,
    SQ_JUMP
  } seq_op_e;

  typedef struct packed {
    alu_op_e            alu;
    logic               mul_en;
    reg_e               mul_a;
    reg_e               mul_b;
    reg_e               mul_dst;
    seq_op_e            seq;
    logic [UaddrW-1:0]  target;
  } ucode_t;

  typedef struct packed {
    alu_op_e alu;
    logic    mul_en;
    reg_e    mul_a;
    reg_e    mul_b;
    reg_e    mul_dst;
    logic    exp_bit;
    logic    out_load;
  } ctrl_t;

  // Microcode addresses.
  localparam logic [UaddrW-1:0] UaIdle  = 4'd0;
  localparam logic [UaddrW-1:0] UaBit   = 4'd1;
  localparam logic [UaddrW-1:0] UaIssB  = 4'd2;
  localparam logic [UaddrW-1:0] UaIssC  = 4'd3;
  localparam logic [UaddrW-1:0] UaWait0 = 4'd4;
  localparam logic [UaddrW-1:0] UaWait1 = 4'd5;
  localparam logic [UaddrW-1:0] UaWait2 = 4'd6;
  localparam logic [UaddrW-1:0] UaAddDe = 4'd7;
  localparam logic [UaddrW-1:0] UaUpd   = 4'd8;
  localparam logic [UaddrW-1:0] UaSum   = 4'd9;
  localparam logic [UaddrW-1:0] UaOfs   = 4'd10;
  localparam logic [UaddrW-1:0] UaOut   = 4'd11;

  function automatic ucode_t uw(alu_op_e alu, logic mul_en, reg_e mul_a, reg_e mul_b,
                                reg_e mul_dst, seq_op_e seq, logic [UaddrW-1:0] target);
    ucode_t w;
    w.alu     = alu;
    w.mul_en  = mul_en;
    w.mul_a   = mul_a;
    w.mul_b   = mul_b;
    w.mul_dst = mul_dst;
    w.seq     = seq;
    w.target  = target;
    return w;
  endfunction

  // The control store. One exponent bit takes the steps from UaBit to UaUpd.
  function automatic ucode_t ucode_rom(logic [UaddrW-1:0] addr);
    ucode_t w;
    unique case (addr)
      UaIdle:  w = uw(ALU_INIT,    1'b0, REG_A, REG_A, REG_C, SQ_IN,   UaIdle);
      UaBit:   w = uw(ALU_TWOB_A,  1'b1, REG_A, REG_A, REG_D, SQ_SKIP, UaIdle);
      UaIssB:  w = uw(ALU_NOP,     1'b1, REG_B, REG_B, REG_E, SQ_NEXT, UaIdle);
      UaIssC:  w = uw(ALU_NOP,     1'b1, REG_A, REG_T, REG_C, SQ_NEXT, UaIdle);
      UaWait0: w = uw(ALU_NOP,     1'b0, REG_A, REG_A, REG_C, SQ_NEXT, UaIdle);
      UaWait1: w = uw(ALU_NOP,     1'b0, REG_A, REG_A, REG_C, SQ_NEXT, UaIdle);
      UaWait2: w = uw(ALU_NOP,     1'b0, REG_A, REG_A, REG_C, SQ_NEXT, UaIdle);
      UaAddDe: w = uw(ALU_ADD_DE,  1'b0, REG_A, REG_A, REG_C, SQ_NEXT, UaIdle);
      UaUpd:   w = uw(ALU_UPDATE,  1'b0, REG_A, REG_A, REG_C, SQ_LOOP, UaBit);
      UaSum:   w = uw(ALU_SUM_AB,  1'b0, REG_A, REG_A, REG_C, SQ_NEXT, UaIdle);
      UaOfs:   w = uw(ALU_SUB_OFS, 1'b0, REG_A, REG_A, REG_C, SQ_NEXT, UaIdle);
      UaOut:   w = uw(ALU_NOP,     1'b0, REG_A, REG_A, REG_C, SQ_OUT,  UaIdle);
      default: w = uw(ALU_NOP,     1'b0, REG_A, REG_A, REG_C, SQ_JUMP, UaIdle);
    endcase
    return w;
  endfunction

  function automatic logic [29:0] mod_add(logic [29:0] x, logic [29:0] y);
    logic [30:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, ModP}) begin
      s = s - {1'b0, ModP};
    end
    return s[29:0];
  endfunction

  // (2b - a) mod P for operands already below P.
  function automatic logic [29:0] mod_twob_a(logic [29:0] b, logic [29:0] a);
    logic [31:0] s;
    s = {1'b0, b, 1'b0} - {2'b00, a};
    if (s[31]) begin
      s = s + {2'b00, ModP};
    end else if (s >= {2'b00, ModP}) begin
      s = s - {2'b00, ModP};
    end
    return s[29:0];
  endfunction

  function automatic logic [29:0] mod_sub_ofs(logic [29:0] x);
    logic [29:0] r;
    if (x < Offset) begin
      r = x + ModP - Offset;
    end else begin
      r = x - Offset;
    end
    return r;
  endfunction

endpackage

### design/mfs_modmul.sv
// Pipelined modular multiplier: product, Barrett quotient estimate,
// quotient times modulus, subtraction, and a final two-way correction.
module mfs_modmul (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 issue_i,
  input  logic [29:0]          a_i,
  input  logic [29:0]          b_i,
  input  mfs_pkg::reg_e        dst_i,
  output logic                 wb_valid_o,
  output mfs_pkg::reg_e        wb_dst_o,
  output logic [29:0]          wb_value_o
);

  logic          v1_q, v2_q, v3_q, v4_q;
  mfs_pkg::reg_e d1_q, d2_q, d3_q, d4_q;
  logic [59:0]   prod_q;
  logic [61:0]   t_q;
  logic [31:0]   x2_q, x3_q, qp_q, r_q;
  logic [61:0]   qp_full;
  logic [31:0]   two_p;
  logic [31:0]   fixed;

  assign qp_full = 62'(t_q[61:31]) * 62'(mfs_pkg::ModP);
  assign two_p   = {1'b0, mfs_pkg::ModP, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= issue_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    d1_q   <= dst_i;
    d2_q   <= d1_q;
    d3_q   <= d2_q;
    d4_q   <= d3_q;
    prod_q <= 60'(a_i) * 60'(b_i);
    t_q    <= 62'(prod_q[59:29]) * 62'(mfs_pkg::BarrettMu);
    x2_q   <= prod_q[31:0];
    qp_q   <= qp_full[31:0];
    x3_q   <= x2_q;
    r_q    <= x3_q - qp_q;
  end

  // The quotient estimate is low by at most two, so r stays below 3P.
  always_comb begin
    if (r_q >= two_p) begin
      fixed = r_q - two_p;
    end else if (r_q >= {2'b00, mfs_pkg::ModP}) begin
      fixed = r_q - {2'b00, mfs_pkg::ModP};
    end else begin
      fixed = r_q;
    end
  end

  assign wb_valid_o = v4_q;
  assign wb_dst_o   = d4_q;
  assign wb_value_o = fixed[29:0];

endmodule

### design/mfs_datapath.sv
// Register file of six residues, the small modular ALU and the multiplier.
module mfs_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mfs_pkg::ctrl_t  ctrl_i,
  output logic [29:0]     result_o
);

  logic [29:0] a_q, b_q, t_q, c_q, d_q, e_q;
  logic [29:0] a_d, b_d, t_d, c_d, d_d, e_d;
  logic [29:0] op_a, op_b;
  logic        wb_valid;
  mfs_pkg::reg_e wb_dst;
  logic [29:0] wb_value;

  function automatic logic [29:0] rd(mfs_pkg::reg_e sel, logic [29:0] a, logic [29:0] b,
                                     logic [29:0] t);
    logic [29:0] v;
    unique case (sel)
      mfs_pkg::REG_A: v = a;
      mfs_pkg::REG_B: v = b;
      mfs_pkg::REG_T: v = t;
      default:        v = '0;
    endcase
    return v;
  endfunction

  assign op_a = rd(ctrl_i.mul_a, a_q, b_q, t_q);
  assign op_b = rd(ctrl_i.mul_b, a_q, b_q, t_q);

  mfs_modmul u_modmul (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .issue_i    (ctrl_i.mul_en),
    .a_i        (op_a),
    .b_i        (op_b),
    .dst_i      (ctrl_i.mul_dst),
    .wb_valid_o (wb_valid),
    .wb_dst_o   (wb_dst),
    .wb_value_o (wb_value)
  );

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    t_d = t_q;
    c_d = c_q;
    d_d = d_q;
    e_d = e_q;
    unique case (ctrl_i.alu)
      mfs_pkg::ALU_NOP: ;
      mfs_pkg::ALU_INIT: begin
        a_d = '0;
        b_d = 30'd1;
      end
      mfs_pkg::ALU_TWOB_A: t_d = mfs_pkg::mod_twob_a(b_q, a_q);
      mfs_pkg::ALU_ADD_DE: d_d = mfs_pkg::mod_add(d_q, e_q);
      mfs_pkg::ALU_UPDATE: begin
        if (ctrl_i.exp_bit) begin
          a_d = d_q;
          b_d = mfs_pkg::mod_add(c_q, d_q);
        end else begin
          a_d = c_q;
          b_d = d_q;
        end
      end
      mfs_pkg::ALU_SUM_AB:  a_d = mfs_pkg::mod_add(a_q, b_q);
      mfs_pkg::ALU_SUB_OFS: a_d = mfs_pkg::mod_sub_ofs(a_q);
      default: ;
    endcase
    if (wb_valid) begin
      case (wb_dst)
        mfs_pkg::REG_C: c_d = wb_value;
        mfs_pkg::REG_D: d_d = wb_value;
        mfs_pkg::REG_E: e_d = wb_value;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
    t_q <= t_d;
    c_q <= c_d;
    d_q <= d_d;
    e_q <= e_d;
  end

  assign result_o = a_q;

endmodule

### design/mfs_sequencer.sv
// Step counter over the control store, with the exponent shifter and the
// bit counter that the conditional jumps look at.
module mfs_sequencer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic [mfs_pkg::IndexW-1:0]    index_n_i,
  input  logic                          out_free_i,
  output logic                          in_ready_o,
  output mfs_pkg::ctrl_t                ctrl_o
);

  logic [mfs_pkg::UaddrW-1:0] addr_q, addr_d;
  logic [mfs_pkg::CntW-1:0]   cnt_q, cnt_d;
  logic [mfs_pkg::ExpW-1:0]   exp_q, exp_d;
  logic                       started_q, started_d;
  mfs_pkg::ucode_t            word;
  logic                       top_bit;
  logic                       skip;

  assign word    = mfs_pkg::ucode_rom(addr_q);
  assign top_bit = exp_q[mfs_pkg::ExpW-1];
  assign skip    = (word.seq == mfs_pkg::SQ_SKIP) && !started_q && !top_bit;

  // Next step.
  always_comb begin
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    exp_d     = exp_q;
    started_d = started_q;
    unique case (word.seq)
      mfs_pkg::SQ_IN: begin
        if (in_valid_i) begin
          addr_d    = 4'(addr_q + 4'd1);
          exp_d     = {1'b0, index_n_i} + 63'd1;
          cnt_d     = mfs_pkg::ExpBits;
          started_d = 1'b0;
        end
      end
      mfs_pkg::SQ_NEXT: addr_d = 4'(addr_q + 4'd1);
      mfs_pkg::SQ_SKIP: begin
        if (skip) begin
          exp_d = {exp_q[mfs_pkg::ExpW-2:0], 1'b0};
          cnt_d = 6'(cnt_q - 6'd1);
        end else begin
          addr_d = 4'(addr_q + 4'd1);
        end
      end
      mfs_pkg::SQ_LOOP: begin
        exp_d = {exp_q[mfs_pkg::ExpW-2:0], 1'b0};
        cnt_d = 6'(cnt_q - 6'd1);
        if (top_bit) begin
          started_d = 1'b1;
        end
        addr_d = (cnt_q == 6'd1) ? 4'(addr_q + 4'd1) : word.target;
      end
      mfs_pkg::SQ_OUT: begin
        if (out_free_i) begin
          addr_d = word.target;
        end
      end
      mfs_pkg::SQ_JUMP: addr_d = word.target;
      default:          addr_d = mfs_pkg::UaIdle;
    endcase
  end

  // Control word to the datapath.
  always_comb begin
    in_ready_o       = (word.seq == mfs_pkg::SQ_IN);
    ctrl_o.alu       = word.alu;
    if ((word.seq == mfs_pkg::SQ_IN) && !in_valid_i) begin
      ctrl_o.alu = mfs_pkg::ALU_NOP;
    end
    ctrl_o.mul_en    = word.mul_en && !skip;
    ctrl_o.mul_a     = word.mul_a;
    ctrl_o.mul_b     = word.mul_b;
    ctrl_o.mul_dst   = word.mul_dst;
    ctrl_o.exp_bit   = top_bit;
    ctrl_o.out_load  = (word.seq == mfs_pkg::SQ_OUT) && out_free_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q    <= mfs_pkg::UaIdle;
      cnt_q     <= '0;
      started_q <= 1'b0;
    end else begin
      addr_q    <= addr_d;
      cnt_q     <= cnt_d;
      started_q <= started_d;
    end
  end

  always_ff @(posedge clk_i) begin
    exp_q <= exp_d;
  end

endmodule

### design/modular_fibonacci_sum_top.sv
// Channel   Direction  Handshake                Payload
// input     in         in_valid_i / in_ready_o  index_n_i   (62 bits, unsigned)
// output    out        out_valid_o / out_ready_i answer_o   (30 bits, unsigned)
//
// One input beat is worked on at a time: it is accepted, the leading zeros of the 63-bit
// exponent e = n + 1 are skipped, and every bit from the leading one down runs the steps from
// UaBit to UaUpd, paced by the four-stage modular multiplier that the three products of a bit
// share. Sum, offset and output load steps follow.
// Reset clears the step counter and the output valid flag. A stalled output beat holds in its
// register; the next input beat is taken while it waits, and only the final load step waits.
module modular_fibonacci_sum_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [mfs_pkg::IndexW-1:0]  index_n_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [mfs_pkg::ValW-1:0]    answer_o
);

  mfs_pkg::ctrl_t           ctrl;
  logic [mfs_pkg::ValW-1:0] result;
  logic                     out_free;
  logic                     out_valid_q, out_valid_d;
  logic [mfs_pkg::ValW-1:0] answer_q;

  // The output register may be reloaded once its beat is gone or leaving.
  assign out_free = !out_valid_q || out_ready_i;

  // The sequencer walks the control store: it takes the index, scans the
  // exponent from its top bit down and skips leading zeros, since the
  // running pair is still F(0), F(1) there.
  mfs_sequencer u_sequencer (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .index_n_i  (index_n_i),
    .out_free_i (out_free),
    .in_ready_o (in_ready_o),
    .ctrl_o     (ctrl)
  );

  // The datapath keeps the pair F(k), F(k+1) and doubles it per bit with
  // F(2k) = F(k)(2F(k+1) - F(k)) and F(2k+1) = F(k)^2 + F(k+1)^2, stepping
  // once more when the bit is set. The final value is F(e) + F(e+1) - 2.
  mfs_datapath u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .result_o (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (ctrl.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      answer_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign answer_o    = answer_q;

endmodule

### tb/modular_fibonacci_sum_top_test.sv
module modular_fibonacci_sum_top_test;

  // The run stops here even if handshakes hang. The slowest correct run is
  // about 620 beats, plus idling and one long hold-off on the output side.
  localparam int unsigned CycleLimit  = 1_500_000;
  localparam int unsigned NumRandom   = 600;
  localparam int unsigned NumDirected = 17;
  // Longest time from an accepted beat to its answer, rounded up.
  localparam int unsigned DrainCycles = 600;
  localparam int unsigned HoldoffLen  = 1500;
  localparam int unsigned HoldoffAt   = 120;

  localparam int unsigned IndexW = mfs_pkg::IndexW;
  localparam int unsigned ValW   = mfs_pkg::ValW;

  localparam logic [63:0] Prime  = 64'(mfs_pkg::ModP);
  localparam logic [63:0] Offs64 = 64'(mfs_pkg::Offset);

  typedef struct packed {
    logic [IndexW-1:0] index;
    logic              known;
    logic [ValW-1:0]   answer;
  } index_row_t;

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_ready_o;
  logic [IndexW-1:0] index_n_i;
  logic              out_valid_o;
  logic              out_ready_i;
  logic [ValW-1:0]   answer_o;

  // Answers still owed by the block, oldest first.
  logic [ValW-1:0] answers_due [$];
  int unsigned     answers_checked;
  int unsigned     mismatches;
  // While set, neither side idles.
  logic            steady;

  index_row_t directed_rows [NumDirected];

  modular_fibonacci_sum_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .index_n_i   (index_n_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .answer_o    (answer_o)
  );

  always #10 clk_i = ~clk_i;

  // Sum of the Fibonacci terms F(2) to F(n+1), i.e. (F(n+3) - 2) mod P.
  // The Fibonacci matrix is raised to the power n + 1 by scanning the
  // exponent from the top bit down: square, then step once when the bit is
  // set. Stepping by Q maps [a b; c d] to [a+b a; c+d c]. All products fit
  // comfortably in 64 bits since every entry stays below P.
  function automatic logic [ValW-1:0] fib_term_sum(logic [IndexW-1:0] n);
    logic [63:0] e;
    logic [63:0] a, b, c, d;
    logic [63:0] sa, sb, sc, sd;
    logic [63:0] top;
    int          i;
    e = {2'b00, n} + 64'd1;
    a = 64'd1;
    b = 64'd0;
    c = 64'd0;
    d = 64'd1;
    for (i = 63; i >= 0; i--) begin
      sa = (a * a + b * c) % Prime;
      sb = (a * b + b * d) % Prime;
      sc = (c * a + d * c) % Prime;
      sd = (c * b + d * d) % Prime;
      if (e[i]) begin
        a = (sa + sb) % Prime;
        b = sa;
        c = (sc + sd) % Prime;
        d = sc;
      end else begin
        a = sa;
        b = sb;
        c = sc;
        d = sd;
      end
    end
    top = (a + b) % Prime;
    // Wrap rather than go negative when the top-row sum is 0 or 1.
    return ValW'((top + Prime - Offs64) % Prime);
  endfunction

  // Offers one index beat and waits for it to be taken. Valid is raised
  // only after any idle cycles, and held with the payload steady until the
  // block accepts. The answer owed is recorded at the accepting edge; the
  // typed-in value stands in for the predictor where the table gives one.
  task automatic offer_index(input logic [IndexW-1:0] n, input logic known,
                             input logic [ValW-1:0] typed);
    while (!steady && $urandom_range(0, 99) < 9) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    index_n_i  <= n;
    @(posedge clk_i);
    while (!in_ready_o) begin
      @(posedge clk_i);
    end
    answers_due.push_back(known ? typed : fib_term_sum(n));
  endtask

  // Output side: checks every accepted answer against the oldest one owed
  // and drives ready. Once a fixed number of answers have been checked it
  // holds ready low for a long stretch, counted here, while the sender goes
  // on offering beats, so the block fills up and must stall its input.
  initial begin : answer_sink
    int unsigned holdoff;
    logic [ValW-1:0] owed;
    holdoff = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        if (answers_due.size() == 0) begin
          $error("answer beat with none owed: answer actual %0d", answer_o);
          mismatches++;
        end else begin
          owed = answers_due.pop_front();
          if (answer_o !== owed) begin
            $error("answer mismatch: expected %0d, actual %0d", owed, answer_o);
            mismatches++;
          end
        end
        answers_checked++;
        if (answers_checked == HoldoffAt) begin
          holdoff = HoldoffLen;
        end
      end
      if (holdoff != 0) begin
        holdoff--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= steady || ($urandom_range(0, 99) >= 9);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin : cycle_watchdog
    int unsigned cycles;
    cycles = 0;
    forever begin
      @(posedge clk_i);
      cycles++;
      if (cycles >= CycleLimit) begin
        $display("modular_fibonacci_sum_top_test NOT OK");
        $finish;
      end
    end
  end

  initial begin : stimulus
    logic [IndexW-1:0] n;
    logic [63:0]       wide;
    int unsigned       k;
    int unsigned       len;

    rst_ni          = 1'b0;
    in_valid_i      = 1'b0;
    index_n_i       = '0;
    out_ready_i     = 1'b0;
    steady          = 1'b0;
    answers_checked = 0;
    mismatches      = 0;

    // Directed table. The first rows are small enough to read the answer
    // straight off the sequence: F(3) - 2 = 0 for the zero index, then
    // 3 - 2, 5 - 2, 8 - 2 and 13 - 2. The rest go through the predictor.
    // Since P is 2 mod 5, F(P+1) = 0 and F(P-1) = 1 modulo P, and the
    // sequence repeats every 2(P+1); those indices drive the top-row sum
    // to 0 or 1 and so exercise the wrap-around on the final subtraction.
    directed_rows = '{
      '{62'd0,                     1'b1, 30'd0},
      '{62'd1,                     1'b1, 30'd1},
      '{62'd2,                     1'b1, 30'd3},
      '{62'd3,                     1'b1, 30'd6},
      '{62'd4,                     1'b1, 30'd11},
      '{62'h3FFF_FFFF_FFFF_FFFF,   1'b0, 30'd0},  // largest index
      '{62'h3FFF_FFFF_FFFF_FFFE,   1'b0, 30'd0},  // exponent all ones
      '{62'h2000_0000_0000_0000,   1'b0, 30'd0},  // top bit alone
      '{62'h1FFF_FFFF_FFFF_FFFF,   1'b0, 30'd0},
      '{62'h2AAA_AAAA_AAAA_AAAA,   1'b0, 30'd0},
      '{62'h1555_5555_5555_5555,   1'b0, 30'd0},
      '{62'd1000000003,            1'b0, 30'd0},  // top-row sum of one
      '{62'd1000000004,            1'b0, 30'd0},
      '{62'd1000000005,            1'b0, 30'd0},  // top-row sum of zero
      '{62'd2000000013,            1'b0, 30'd0},  // zero, one period on
      '{62'd2000000014,            1'b0, 30'd0},  // one, one period on
      '{62'h0000_0000_FFFF_FFFF,   1'b0, 30'd0}
    };

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      offer_index(directed_rows[r].index, directed_rows[r].known,
                  directed_rows[r].answer);
    end

    // Random beats. Most indices are short, which keeps the run quick;
    // some are full width, and some sit just below a multiple of P + 1 so
    // that the wrap-around case keeps turning up.
    for (int unsigned i = 0; i < NumRandom; i++) begin
      if (i == 300) begin
        // Hold the input back until every answer owed has come out.
        in_valid_i <= 1'b0;
        do begin
          @(posedge clk_i);
        end while (answers_due.size() != 0);
      end
      steady = (i >= 350) && (i < 450);
      wide = {$urandom, $urandom};
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          len = $urandom_range(1, 20);
          n   = IndexW'(wide & ((64'd1 << len) - 64'd1));
        end
        6, 7: begin
          n = IndexW'(wide);
        end
        8: begin
          k = $urandom_range(1, 4);
          n = IndexW'(64'(k) * (Prime + 64'd1) - 64'(3) - 64'($urandom_range(0, 2))
                      + 64'($urandom_range(0, 2)));
        end
        default: begin
          len = $urandom_range(21, 62);
          n   = IndexW'(wide & ((64'd1 << len) - 64'd1));
        end
      endcase
      offer_index(n, 1'b0, '0);
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Let every owed answer arrive, then watch a while longer for strays.
    while (answers_due.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("modular_fibonacci_sum_top_test OK");
    end else begin
      $display("modular_fibonacci_sum_top_test NOT OK");
    end
    $finish;
  end

endmodule

### files.f
design/mfs_pkg.sv
design/mfs_modmul.sv
design/mfs_datapath.sv
design/mfs_sequencer.sv
design/modular_fibonacci_sum_top.sv
tb/modular_fibonacci_sum_top_test.sv
